### src/bll_pkg.sv
`timescale 1ns / 1ps

package bll_pkg;

  // store geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;

  // command codes
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_REMOVE     = 2'd2;
  localparam logic [1:0] CMD_DUMP       = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_POS = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

endpackage

### src/bounded_linked_list_engine_top.sv
`timescale 1ns / 1ps

// channel   direction  signals                                        handshake
// command   in         command_i, value_i, position_i                 start_i high, busy_o low
// result    out        item_value_o, list_count_o, status_o, last_o   valid_o strobe, one cycle
//
// every result appears in the cycle after the one that produced it, for one cycle only.
// push front, push back onto an empty list, a rejected command and an empty dump keep
// busy_o low; any other push back goes busy in S_PB_LINK to link the old tail.
// remove at position p stays busy while it walks to it: one link memory read per hop.
// dump of n entries gives one value per cycle from the memory read port, busy until the last.
// reset clears head, tail, count and the free map at once; the memories need no clearing.
// the receiver cannot stall; a new command may be accepted while a result is on the ports.

module bounded_linked_list_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         command_i,
  input  logic signed [bll_pkg::VAL_W-1:0]   value_i,
  input  logic [bll_pkg::POS_W-1:0]          position_i,
  output logic                               valid_o,
  output logic signed [bll_pkg::VAL_W-1:0]   item_value_o,
  output logic [bll_pkg::CNT_W-1:0]          list_count_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PB_LINK   = 3'd1;
  localparam logic [2:0] S_RM_HEAD   = 3'd2;
  localparam logic [2:0] S_RM_WALK   = 3'd3;
  localparam logic [2:0] S_RM_UNLINK = 3'd4;
  localparam logic [2:0] S_DUMP      = 3'd5;

  localparam logic [bll_pkg::CNT_W-1:0] CAP_CNT = bll_pkg::CNT_W'(bll_pkg::CAPACITY);
  localparam logic [bll_pkg::CNT_W-1:0] ONE_CNT = bll_pkg::CNT_W'(1);

  // memories
  logic signed [bll_pkg::VAL_W-1:0] value_mem [bll_pkg::CAPACITY];
  logic [bll_pkg::IDX_W-1:0]        link_mem  [bll_pkg::CAPACITY];

  logic signed [bll_pkg::VAL_W-1:0] value_rdata_q;
  logic [bll_pkg::IDX_W-1:0]        link_rdata_q;
  logic [bll_pkg::IDX_W-1:0]        rd_addr;
  logic                             value_we;
  logic [bll_pkg::IDX_W-1:0]        value_waddr;
  logic                             link_we;
  logic [bll_pkg::IDX_W-1:0]        link_waddr;
  logic [bll_pkg::IDX_W-1:0]        link_wdata;

  // control and list registers
  logic [2:0]                       state_q, state_d;
  logic [bll_pkg::IDX_W-1:0]        head_q, head_d;
  logic [bll_pkg::IDX_W-1:0]        tail_q, tail_d;
  logic [bll_pkg::CNT_W-1:0]        count_q, count_d;
  logic [bll_pkg::CAPACITY-1:0]     free_map_q, free_map_d;
  logic [bll_pkg::IDX_W-1:0]        cur_q, cur_d;
  logic [bll_pkg::IDX_W-1:0]        prev_q, prev_d;
  logic [bll_pkg::IDX_W-1:0]        victim_q, victim_d;
  logic [bll_pkg::IDX_W-1:0]        hops_q, hops_d;
  logic [bll_pkg::CNT_W-1:0]        left_q, left_d;
  logic                             rm_tail_q, rm_tail_d;

  // result registers
  logic                             valid_q, valid_d;
  logic signed [bll_pkg::VAL_W-1:0] res_value_q, res_value_d;
  logic [bll_pkg::CNT_W-1:0]        res_count_q, res_count_d;
  logic [1:0]                       res_status_q, res_status_d;
  logic                             res_last_q, res_last_d;

  logic                             accept;
  logic [bll_pkg::IDX_W-1:0]        free_idx;
  logic                             pos_bad;

  assign accept  = start_i && (state_q == S_IDLE);
  assign busy_o  = (state_q != S_IDLE);
  assign pos_bad = (position_i == '0) || (position_i > {1'b0, count_q});

  // lowest free entry
  always_comb begin
    free_idx = '0;
    for (int i = bll_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (free_map_q[i]) begin
        free_idx = bll_pkg::IDX_W'(i);
      end
    end
  end

  // command sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    free_map_d   = free_map_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    victim_d     = victim_q;
    hops_d       = hops_q;
    left_d       = left_q;
    rm_tail_d    = rm_tail_q;
    valid_d      = 1'b0;
    res_value_d  = '0;
    res_count_d  = count_q;
    res_status_d = bll_pkg::ST_OK;
    res_last_d   = 1'b1;
    rd_addr      = head_q;
    value_we     = 1'b0;
    value_waddr  = free_idx;
    link_we      = 1'b0;
    link_waddr   = free_idx;
    link_wdata   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            bll_pkg::CMD_PUSH_FRONT, bll_pkg::CMD_PUSH_BACK: begin
              valid_d = 1'b1;
              if (count_q == CAP_CNT) begin
                res_status_d = bll_pkg::ST_FULL;
              end else begin
                value_we                 = 1'b1;
                link_we                  = 1'b1;
                free_map_d[free_idx]     = 1'b0;
                count_d                  = count_q + ONE_CNT;
                res_count_d              = count_q + ONE_CNT;
                if (command_i == bll_pkg::CMD_PUSH_FRONT) begin
                  link_wdata = head_q;
                  head_d     = free_idx;
                  if (count_q == '0) begin
                    tail_d = free_idx;
                  end
                end else begin
                  tail_d = free_idx;
                  if (count_q == '0) begin
                    head_d = free_idx;
                  end else begin
                    // old tail gets its link in the next cycle
                    prev_d  = tail_q;
                    cur_d   = free_idx;
                    state_d = S_PB_LINK;
                  end
                end
              end
            end
            bll_pkg::CMD_REMOVE: begin
              if (pos_bad) begin
                valid_d      = 1'b1;
                res_status_d = bll_pkg::ST_BAD_POS;
              end else if (position_i == 8'd1) begin
                state_d = S_RM_HEAD;
              end else begin
                cur_d     = head_q;
                hops_d    = position_i[bll_pkg::IDX_W-1:0] - bll_pkg::IDX_W'(2);
                rm_tail_d = (position_i == {1'b0, count_q});
                state_d   = S_RM_WALK;
              end
            end
            default: begin
              if (count_q == '0) begin
                valid_d      = 1'b1;
                res_status_d = bll_pkg::ST_EMPTY;
              end else begin
                left_d  = count_q;
                state_d = S_DUMP;
              end
            end
          endcase
        end
      end

      S_PB_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = cur_q;
        state_d    = S_IDLE;
      end

      S_RM_HEAD: begin
        free_map_d[head_q] = 1'b1;
        count_d            = count_q - ONE_CNT;
        res_count_d        = count_q - ONE_CNT;
        valid_d            = 1'b1;
        if (count_q == ONE_CNT) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = link_rdata_q;
        end
        state_d = S_IDLE;
      end

      S_RM_WALK: begin
        // link_rdata_q holds the link of cur_q
        if (hops_q == '0) begin
          prev_d   = cur_q;
          victim_d = link_rdata_q;
          rd_addr  = link_rdata_q;
          state_d  = S_RM_UNLINK;
        end else begin
          cur_d   = link_rdata_q;
          rd_addr = link_rdata_q;
          hops_d  = hops_q - bll_pkg::IDX_W'(1);
        end
      end

      S_RM_UNLINK: begin
        // splice the victim out
        link_we              = 1'b1;
        link_waddr           = prev_q;
        link_wdata           = link_rdata_q;
        free_map_d[victim_q] = 1'b1;
        count_d              = count_q - ONE_CNT;
        res_count_d          = count_q - ONE_CNT;
        valid_d              = 1'b1;
        if (rm_tail_q) begin
          tail_d = prev_q;
        end
        state_d = S_IDLE;
      end

      S_DUMP: begin
        valid_d     = 1'b1;
        res_value_d = value_rdata_q;
        res_last_d  = (left_q == ONE_CNT);
        rd_addr     = link_rdata_q;
        left_d      = left_q - ONE_CNT;
        if (left_q == ONE_CNT) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // value and link memories, registered read
  always_ff @(posedge clk_i) begin
    if (value_we) begin
      value_mem[value_waddr] <= value_i;
    end
    value_rdata_q <= value_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata_q <= link_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      free_map_q <= '1;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      free_map_q <= free_map_d;
      valid_q    <= valid_d;
    end
  end

  // walk and result payload
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    victim_q     <= victim_d;
    hops_q       <= hops_d;
    left_q       <= left_d;
    rm_tail_q    <= rm_tail_d;
    res_value_q  <= res_value_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign valid_o      = valid_q;
  assign item_value_o = res_value_q;
  assign list_count_o = res_count_q;
  assign status_o     = res_status_q;
  assign last_o       = res_last_q;

`ifndef ASSERT_OFF
  // free entries and list entries always account for the whole store
  a_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_map_q) == (bll_pkg::CAPACITY - int'(count_q)))
    else $error("free map disagrees with entry count");

  // count stays within capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  // dump walk only runs on a non-empty list with entries left
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (count_q != '0) && (left_q != '0) && (left_q <= count_q))
    else $error("dump walk on empty list");

  // intermediate dump results carry ok status
  a_mid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (status_o == bll_pkg::ST_OK))
    else $error("non-final result with error status");

  // a rejected push reports the count unchanged, at capacity
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == bll_pkg::ST_FULL) |-> (list_count_o == CAP_CNT))
    else $error("full status below capacity");
`endif

endmodule

### bench/bll_result_checker.sv
`timescale 1ns / 1ps

module bll_result_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic [1:0]                         command_i,
  input  logic signed [bll_pkg::VAL_W-1:0]   value_i,
  input  logic [bll_pkg::POS_W-1:0]          position_i,
  input  logic                               valid_i,
  input  logic signed [bll_pkg::VAL_W-1:0]   item_value_i,
  input  logic [bll_pkg::CNT_W-1:0]          list_count_i,
  input  logic [1:0]                         status_i,
  input  logic                               last_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  import bll_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic [CNT_W-1:0]        list_count;
    logic [1:0]              status;
    logic                    last;
  } list_result_t;

  // shadow copy of the list store
  logic signed [VAL_W-1:0] value_mem [CAPACITY];
  logic [IDX_W-1:0]        link_mem  [CAPACITY];
  logic [IDX_W-1:0]        head_idx;
  logic [IDX_W-1:0]        tail_idx;
  logic [CNT_W-1:0]        entry_cnt;
  logic [CAPACITY-1:0]     free_bits;

  list_result_t expected_results [$];
  list_result_t oldest;
  int           fail_cnt = 0;

  function automatic void add_expected(input logic signed [VAL_W-1:0] v,
                                       input logic [CNT_W-1:0] c,
                                       input logic [1:0] s,
                                       input logic l);
    list_result_t r;
    r.item_value = v;
    r.list_count = c;
    r.status     = s;
    r.last       = l;
    expected_results.push_back(r);
  endfunction

  // update the shadow list for one command and queue what it should produce
  function automatic void apply_command(input logic [1:0] cmd,
                                        input logic signed [VAL_W-1:0] val,
                                        input logic [POS_W-1:0] pos);
    int               slot;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] victim;
    logic [IDX_W-1:0] cur;
    slot = -1;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        // lowest free entry wins
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (free_bits[i]) slot = i;
        end
        if (entry_cnt >= CAPACITY || slot < 0) begin
          add_expected('0, entry_cnt, ST_FULL, 1'b1);
        end else begin
          free_bits[slot] = 1'b0;
          value_mem[slot] = val;
          if (cmd == CMD_PUSH_FRONT) begin
            link_mem[slot] = head_idx;
            if (entry_cnt == 0) tail_idx = IDX_W'(slot);
            head_idx = IDX_W'(slot);
          end else begin
            link_mem[slot] = '0;
            if (entry_cnt == 0) head_idx = IDX_W'(slot);
            else link_mem[tail_idx] = IDX_W'(slot);
            tail_idx = IDX_W'(slot);
          end
          entry_cnt = entry_cnt + 1'b1;
          add_expected('0, entry_cnt, ST_OK, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (pos == 0 || pos > entry_cnt) begin
          add_expected('0, entry_cnt, ST_BAD_POS, 1'b1);
        end else begin
          if (pos == 1) begin
            victim   = head_idx;
            head_idx = link_mem[victim];
          end else begin
            // walk to the entry just ahead of the one going away
            prev = head_idx;
            for (int i = 1; i < int'(pos) - 1; i++) prev = link_mem[prev];
            victim         = link_mem[prev];
            link_mem[prev] = link_mem[victim];
            if (pos == entry_cnt) tail_idx = prev;
          end
          free_bits[victim] = 1'b1;
          entry_cnt = entry_cnt - 1'b1;
          if (entry_cnt == 0) begin
            head_idx = '0;
            tail_idx = '0;
          end
          add_expected('0, entry_cnt, ST_OK, 1'b1);
        end
      end
      default: begin
        // dump from head to tail
        if (entry_cnt == 0) begin
          add_expected('0, '0, ST_EMPTY, 1'b1);
        end else begin
          cur = head_idx;
          for (int k = 0; k < int'(entry_cnt); k++) begin
            add_expected(value_mem[cur], entry_cnt, ST_OK, k == int'(entry_cnt) - 1);
            cur = link_mem[cur];
          end
        end
      end
    endcase
  endfunction

  // compare each result transfer, then predict for each accepted command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx  = '0;
      tail_idx  = '0;
      entry_cnt = '0;
      free_bits = '1;
      expected_results.delete();
    end else begin
      if (valid_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: item_value %0d list_count %0d status %0d last %0d",
                 item_value_i, list_count_i, status_i, last_i);
          fail_cnt++;
        end else begin
          oldest = expected_results.pop_front();
          if (item_value_i !== oldest.item_value) begin
            $error("item_value: expected %0d, got %0d", oldest.item_value, item_value_i);
            fail_cnt++;
          end
          if (list_count_i !== oldest.list_count) begin
            $error("list_count: expected %0d, got %0d", oldest.list_count, list_count_i);
            fail_cnt++;
          end
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, status_i);
            fail_cnt++;
          end
          if (last_i !== oldest.last) begin
            $error("last: expected %0d, got %0d", oldest.last, last_i);
            fail_cnt++;
          end
        end
      end
      if (start_i && !busy_i) apply_command(command_i, value_i, position_i);
    end
    fail_count_o <= fail_cnt;
    pending_o    <= expected_results.size();
  end

endmodule

### bench/bounded_linked_list_engine_top_tb.sv
`timescale 1ns / 1ps

module bounded_linked_list_engine_top_tb;

  import bll_pkg::*;

  localparam int RANDOM_ITEMS   = 305;
  localparam int QUIET_TAIL     = 60;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    start_i    = 1'b0;
  logic [1:0]              command_i  = CMD_PUSH_FRONT;
  logic signed [VAL_W-1:0] value_i    = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic                    busy_o;
  logic                    valid_o;
  logic signed [VAL_W-1:0] item_value_o;
  logic [CNT_W-1:0]        list_count_o;
  logic [1:0]              status_o;
  logic                    last_o;

  int fail_count;
  int pending_results;
  int list_len     = 0;
  int gap_pct      = 30;
  int quiet_cycles = 0;

  bounded_linked_list_engine_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .valid_o      (valid_o),
    .item_value_o (item_value_o),
    .list_count_o (list_count_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  bll_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .valid_i      (valid_o),
    .item_value_i (item_value_o),
    .list_count_i (list_count_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL bounded_linked_list_engine_top");
      $finish;
    end
  end

  // one command transfer, with an optional idle burst ahead of it
  task automatic issue_command(input logic [1:0] cmd,
                               input logic signed [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    int gap;
    if ($urandom_range(99) < gap_pct) begin
      gap = $urandom_range(6, 1);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (busy_o);
    // track the length to aim removes at live positions
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: if (list_len < CAPACITY) list_len++;
      CMD_REMOVE: if (pos != 0 && pos <= list_len) list_len--;
      default: ;
    endcase
  endtask

  task automatic random_command(input int push_pct, input int remove_pct);
    int                      roll;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    logic [1:0]              cmd;
    roll = $urandom_range(99);
    val  = $urandom;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: val = 32'sh7fff_ffff;
        1: val = 32'sh8000_0000;
        2: val = -32'sd1;
        default: val = '0;
      endcase
    end
    if (list_len > 0 && $urandom_range(4) != 0) pos = POS_W'($urandom_range(list_len, 1));
    else pos = POS_W'($urandom_range(255));
    if (roll < push_pct) cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    else if (roll < push_pct + remove_pct) cmd = CMD_REMOVE;
    else cmd = CMD_DUMP;
    issue_command(cmd, val, pos);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes, head, middle and tail removal, bad positions
    issue_command(CMD_DUMP, '0, '0);
    issue_command(CMD_REMOVE, '0, 8'd1);
    issue_command(CMD_REMOVE, '0, 8'd0);
    issue_command(CMD_PUSH_BACK, 32'sh7fff_ffff, 8'd0);
    issue_command(CMD_PUSH_FRONT, 32'sh8000_0000, 8'hff);
    issue_command(CMD_PUSH_BACK, '0, '0);
    issue_command(CMD_PUSH_FRONT, -32'sd1, '0);
    issue_command(CMD_DUMP, 32'sh5a5a_a5a5, 8'h55);
    issue_command(CMD_REMOVE, '0, 8'd0);
    issue_command(CMD_REMOVE, '0, 8'd5);
    issue_command(CMD_REMOVE, '0, 8'd255);
    issue_command(CMD_REMOVE, '0, 8'd4);
    issue_command(CMD_PUSH_BACK, 32'sd12345, '0);
    issue_command(CMD_REMOVE, '0, 8'd2);
    issue_command(CMD_REMOVE, '0, 8'd1);
    issue_command(CMD_DUMP, '0, '0);
    issue_command(CMD_REMOVE, '0, 8'd2);
    issue_command(CMD_REMOVE, '0, 8'd1);
    // emptied list must restart cleanly from head and tail
    issue_command(CMD_PUSH_BACK, 32'sd7, '0);
    issue_command(CMD_PUSH_FRONT, 32'sd5, '0);
    issue_command(CMD_DUMP, '0, '0);
    issue_command(CMD_REMOVE, '0, 8'd2);
    issue_command(CMD_REMOVE, '0, 8'd1);
    issue_command(CMD_DUMP, '0, '0);

    // random: push-heavy phases toward full, a remove-heavy phase to drain, then mixed
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) gap_pct = ($urandom_range(2) == 0) ? 0 : 35;
      if (i >= RANDOM_ITEMS - QUIET_TAIL) gap_pct = 0;
      if (i < 100) random_command(85, 7);
      else if (i < 130) random_command(60, 20);
      else if (i < 220) random_command(15, 75);
      else random_command(45, 40);
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results != 0) $error("%0d expected results never arrived", pending_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS bounded_linked_list_engine_top");
    end else begin
      $display("FAIL bounded_linked_list_engine_top");
    end
    $finish;
  end

endmodule

### filelist.f
src/bll_pkg.sv
src/bounded_linked_list_engine_top.sv
bench/bll_result_checker.sv
bench/bounded_linked_list_engine_top_tb.sv
